### hw/rtl/swas_pkg.sv
// Shared types, codes and helpers for the sliding window access stats block.
// No dependencies; used by every module under hw/rtl except swas_ram.
`timescale 1ns / 1ps
package swas_pkg;

  localparam logic [1:0] CMD_RECORD = 2'd0;
  localparam logic [1:0] CMD_WTIME  = 2'd1;
  localparam logic [1:0] CMD_SNAP   = 2'd2;

  localparam logic [1:0] AT_LOOKUP = 2'd1;
  localparam logic [1:0] AT_RANGE  = 2'd2;
  localparam logic [1:0] AT_FULL   = 2'd3;

  localparam logic [1:0] CFG_FAST = 2'd0;
  localparam logic [1:0] CFG_MID  = 2'd1;
  localparam logic [1:0] CFG_SLOW = 2'd2;

  localparam int WIDTH_W   = 17;
  localparam int DIV_STEPS = 32;
  localparam logic [41:0] MS_PER_SEC = 42'd1000;
  localparam logic [WIDTH_W-1:0] FAST_W_RST = 17'd5;
  localparam logic [WIDTH_W-1:0] MID_W_RST  = 17'd60;
  localparam logic [WIDTH_W-1:0] SLOW_W_RST = 17'd3600;

  typedef struct packed {
    logic [31:0] lookups;
    logic [31:0] reads;
    logic [31:0] tag;
  } fast_ent_t;

  typedef struct packed {
    logic [47:0] rows;
    logic [47:0] bytes;
    logic [31:0] full_scans;
    logic [31:0] range_scans;
    logic [31:0] lookups;
    logic [31:0] reads;
    logic [31:0] tag;
  } mid_ent_t;

  typedef struct packed {
    logic [31:0] reads;
    logic [31:0] tag;
  } slow_ent_t;

  typedef struct packed {
    logic start;
    logic div_step;
    logic ram_rd;
    logic ram_wr;
    logic sweep_step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic       div_last;
    logic       sweep_last;
    logic       out_free;
    logic [1:0] cmd;
  } ctrl_st_t;

  function automatic logic [31:0] inc32(input logic [31:0] x);
    inc32 = (x == 32'hFFFF_FFFF) ? x : x + 32'd1;
  endfunction

  function automatic logic [47:0] add48(input logic [47:0] a, input logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    add48 = s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
  endfunction

endpackage

### hw/rtl/swas_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module swas_ram #(
  parameter int W = 32,
  parameter int D = 60,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] addr_i,
  input  logic [W-1:0]  wdata_i,
  output logic [W-1:0]  rdata_o
);
  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;
endmodule

### hw/rtl/swas_div.sv
// Bit-serial divider: epoch = now / width and slot = epoch mod N, one bit a step.
// Depends on swas_pkg.
`timescale 1ns / 1ps
module swas_div #(
  parameter int N = 60,
  localparam int SW = (N > 1) ? $clog2(N) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        step_i,
  input  logic [31:0]                 dividend_i,
  input  logic [swas_pkg::WIDTH_W-1:0] width_i,
  output logic [31:0]                 epoch_o,
  output logic [SW-1:0]               slot_o
);
  localparam int RW = swas_pkg::WIDTH_W;

  logic [31:0]   n_q, n_d, q_q, q_d;
  logic [RW-1:0] r_q, r_d, d_q, d_d;
  logic [SW-1:0] s_q, s_d;
  logic [RW:0]   t;
  logic          ge;
  logic [SW:0]   u;

  always_comb begin
    t   = {r_q, n_q[31]};
    ge  = t >= {1'b0, d_q};
    u   = {s_q, ge};
    n_d = n_q;
    q_d = q_q;
    r_d = r_q;
    d_d = d_q;
    s_d = s_q;
    if (start_i) begin
      n_d = dividend_i;
      q_d = '0;
      r_d = '0;
      s_d = '0;
      d_d = (width_i == '0) ? RW'(1) : width_i;
    end else if (step_i) begin
      n_d = {n_q[30:0], 1'b0};
      q_d = {q_q[30:0], ge};
      r_d = ge ? RW'(t - {1'b0, d_q}) : t[RW-1:0];
      s_d = (u >= (SW+1)'(N)) ? SW'(u - (SW+1)'(N)) : u[SW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= '0;
      q_q <= '0;
      r_q <= '0;
      d_q <= RW'(1);
      s_q <= '0;
    end else begin
      n_q <= n_d;
      q_q <= q_d;
      r_q <= r_d;
      d_q <= d_d;
      s_q <= s_d;
    end
  end

  assign epoch_o = q_q;
  assign slot_o  = s_q;
endmodule

### hw/rtl/swas_ctrl.sv
// Controller state machine: sequences divide, bucket update, snapshot sweep and result load.
// Depends on swas_pkg.
`timescale 1ns / 1ps
module swas_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [1:0]          in_cmd_i,
  output logic                in_ready_o,
  input  swas_pkg::ctrl_st_t  st_i,
  output swas_pkg::ctrl_cmd_t cmd_o
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_WR   = 3'd3;
  localparam logic [2:0] S_SNAP = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          if (in_cmd_i == swas_pkg::CMD_RECORD || in_cmd_i == swas_pkg::CMD_SNAP) begin
            state_d = S_DIV;
          end
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (st_i.div_last) begin
          state_d = (st_i.cmd == swas_pkg::CMD_RECORD) ? S_RD : S_SNAP;
        end
      end
      S_RD: begin
        cmd_o.ram_rd = 1'b1;
        state_d      = S_WR;
      end
      S_WR: begin
        cmd_o.ram_wr = 1'b1;
        state_d      = S_IDLE;
      end
      S_SNAP: begin
        cmd_o.sweep_step = 1'b1;
        if (st_i.sweep_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (st_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

### hw/rtl/swas_dp.sv
// Datapath: width registers, dividers, bucket RAMs, valid bits, sums and result register.
// Depends on swas_pkg, swas_div and swas_ram.
`timescale 1ns / 1ps
module swas_dp #(
  parameter int FAST_BUCKETS = 60,
  parameter int MID_BUCKETS  = 60,
  parameter int SLOW_BUCKETS = 24
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [swas_pkg::WIDTH_W-1:0] cfg_wdata_i,
  input  logic [1:0]                  in_cmd_i,
  input  logic [1:0]                  in_type_i,
  input  logic [31:0]                 in_now_i,
  input  logic [31:0]                 in_bytes_i,
  input  logic [31:0]                 in_rows_i,
  input  logic [41:0]                 in_wms_i,
  input  swas_pkg::ctrl_cmd_t         cmd_i,
  output swas_pkg::ctrl_st_t          st_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [519:0]                out_data_o
);
  localparam int FAW  = (FAST_BUCKETS > 1) ? $clog2(FAST_BUCKETS) : 1;
  localparam int MAW  = (MID_BUCKETS > 1) ? $clog2(MID_BUCKETS) : 1;
  localparam int SAW  = (SLOW_BUCKETS > 1) ? $clog2(SLOW_BUCKETS) : 1;
  localparam int MAXN = (FAST_BUCKETS > MID_BUCKETS) ?
                        ((FAST_BUCKETS > SLOW_BUCKETS) ? FAST_BUCKETS : SLOW_BUCKETS) :
                        ((MID_BUCKETS > SLOW_BUCKETS) ? MID_BUCKETS : SLOW_BUCKETS);
  localparam int SWW  = $clog2(MAXN + 2);
  localparam int FEW  = $bits(swas_pkg::fast_ent_t);
  localparam int MEW  = $bits(swas_pkg::mid_ent_t);
  localparam int SEW  = $bits(swas_pkg::slow_ent_t);
  localparam int WW   = swas_pkg::WIDTH_W;

  function automatic logic in_win(input logic [31:0] tag, input logic [31:0] cur,
                                  input logic [31:0] n);
    in_win = (tag <= cur) && ((cur - tag) < n);
  endfunction

  logic [WW-1:0] fw_q, mw_q, sw_q;
  logic [1:0]  cmd_q;
  logic [1:0]  type_q;
  logic [31:0] now_q, bytes_q, rows_q;
  logic [41:0] wtime_q, atime_q;
  logic [4:0]  dc_q;
  logic [SWW-1:0] sc_q, sc_m1;

  logic [31:0]    fe, me, se;
  logic [FAW-1:0] fslot, faddr;
  logic [MAW-1:0] mslot, maddr;
  logic [SAW-1:0] sslot, saddr;

  logic [FAST_BUCKETS-1:0] fvalid_q;
  logic [MID_BUCKETS-1:0]  mvalid_q;
  logic [SLOW_BUCKETS-1:0] svalid_q;

  logic [FEW-1:0] frd;
  logic [MEW-1:0] mrd;
  logic [SEW-1:0] srd;
  swas_pkg::fast_ent_t fent, fnew;
  swas_pkg::mid_ent_t  ment, mnew;
  swas_pkg::slow_ent_t sent, snew;

  logic [47:0] acc_q [9];
  logic        out_valid_q;
  logic [519:0] out_q;
  logic        sweep, facc, macc, sacc;

  // width registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= swas_pkg::FAST_W_RST;
      mw_q <= swas_pkg::MID_W_RST;
      sw_q <= swas_pkg::SLOW_W_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        swas_pkg::CFG_FAST: fw_q <= cfg_wdata_i;
        swas_pkg::CFG_MID:  mw_q <= cfg_wdata_i;
        swas_pkg::CFG_SLOW: sw_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  swas_div #(.N(FAST_BUCKETS)) u_div_fast (
    .clk_i, .rst_ni, .start_i(cmd_i.start), .step_i(cmd_i.div_step),
    .dividend_i(in_now_i), .width_i(fw_q), .epoch_o(fe), .slot_o(fslot)
  );
  swas_div #(.N(MID_BUCKETS)) u_div_mid (
    .clk_i, .rst_ni, .start_i(cmd_i.start), .step_i(cmd_i.div_step),
    .dividend_i(in_now_i), .width_i(mw_q), .epoch_o(me), .slot_o(mslot)
  );
  swas_div #(.N(SLOW_BUCKETS)) u_div_slow (
    .clk_i, .rst_ni, .start_i(cmd_i.start), .step_i(cmd_i.div_step),
    .dividend_i(in_now_i), .width_i(sw_q), .epoch_o(se), .slot_o(sslot)
  );

  // item capture, step counters, scalar state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q   <= swas_pkg::CMD_RECORD;
      dc_q    <= '0;
      sc_q    <= '0;
      wtime_q <= '0;
      atime_q <= '0;
    end else begin
      if (cmd_i.start) begin
        cmd_q <= in_cmd_i;
        dc_q  <= '0;
        sc_q  <= '0;
        if (in_cmd_i == swas_pkg::CMD_WTIME && in_wms_i > wtime_q) begin
          wtime_q <= in_wms_i;
        end
      end else begin
        if (cmd_i.div_step) dc_q <= dc_q + 5'd1;
        if (cmd_i.sweep_step) sc_q <= sc_q + SWW'(1);
      end
      if (cmd_i.ram_wr) begin
        atime_q <= 42'(now_q) * swas_pkg::MS_PER_SEC;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      type_q  <= in_type_i;
      now_q   <= in_now_i;
      bytes_q <= in_bytes_i;
      rows_q  <= in_rows_i;
    end
  end

  assign sweep = cmd_i.sweep_step;
  assign sc_m1 = sc_q - SWW'(1);
  assign faddr = sweep ? ((sc_q < SWW'(FAST_BUCKETS)) ? sc_q[FAW-1:0] : '0) : fslot;
  assign maddr = sweep ? ((sc_q < SWW'(MID_BUCKETS)) ? sc_q[MAW-1:0] : '0) : mslot;
  assign saddr = sweep ? ((sc_q < SWW'(SLOW_BUCKETS)) ? sc_q[SAW-1:0] : '0) : sslot;

  swas_ram #(.W(FEW), .D(FAST_BUCKETS)) u_ram_fast (
    .clk_i, .we_i(cmd_i.ram_wr), .addr_i(faddr), .wdata_i(FEW'(fnew)), .rdata_o(frd)
  );
  swas_ram #(.W(MEW), .D(MID_BUCKETS)) u_ram_mid (
    .clk_i, .we_i(cmd_i.ram_wr), .addr_i(maddr), .wdata_i(MEW'(mnew)), .rdata_o(mrd)
  );
  swas_ram #(.W(SEW), .D(SLOW_BUCKETS)) u_ram_slow (
    .clk_i, .we_i(cmd_i.ram_wr), .addr_i(saddr), .wdata_i(SEW'(snew)), .rdata_o(srd)
  );

  assign fent = swas_pkg::fast_ent_t'(frd);
  assign ment = swas_pkg::mid_ent_t'(mrd);
  assign sent = swas_pkg::slow_ent_t'(srd);

  // bucket update: clear on stale tag, then count
  always_comb begin
    swas_pkg::fast_ent_t fb;
    swas_pkg::mid_ent_t  mb;
    swas_pkg::slow_ent_t sb;
    fb = (fvalid_q[fslot] && fent.tag == fe) ? fent : '0;
    mb = (mvalid_q[mslot] && ment.tag == me) ? ment : '0;
    sb = (svalid_q[sslot] && sent.tag == se) ? sent : '0;
    fnew = fb;
    mnew = mb;
    snew = sb;
    fnew.tag   = fe;
    mnew.tag   = me;
    snew.tag   = se;
    fnew.reads = swas_pkg::inc32(fb.reads);
    mnew.reads = swas_pkg::inc32(mb.reads);
    snew.reads = swas_pkg::inc32(sb.reads);
    case (type_q)
      swas_pkg::AT_LOOKUP: begin
        fnew.lookups = swas_pkg::inc32(fb.lookups);
        mnew.lookups = swas_pkg::inc32(mb.lookups);
      end
      swas_pkg::AT_RANGE: mnew.range_scans = swas_pkg::inc32(mb.range_scans);
      swas_pkg::AT_FULL:  mnew.full_scans  = swas_pkg::inc32(mb.full_scans);
      default: ;
    endcase
    mnew.bytes = swas_pkg::add48(mb.bytes, 48'(bytes_q));
    mnew.rows  = swas_pkg::add48(mb.rows, 48'(rows_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fvalid_q <= '0;
      mvalid_q <= '0;
      svalid_q <= '0;
    end else if (cmd_i.ram_wr) begin
      fvalid_q[fslot] <= 1'b1;
      mvalid_q[mslot] <= 1'b1;
      svalid_q[sslot] <= 1'b1;
    end
  end

  // sweep: data of address sc_q-1 arrives while sc_q is issued
  assign facc = sweep && sc_q != '0 && sc_m1 < SWW'(FAST_BUCKETS) &&
                fvalid_q[sc_m1[FAW-1:0]] && in_win(fent.tag, fe, 32'(FAST_BUCKETS));
  assign macc = sweep && sc_q != '0 && sc_m1 < SWW'(MID_BUCKETS) &&
                mvalid_q[sc_m1[MAW-1:0]] && in_win(ment.tag, me, 32'(MID_BUCKETS));
  assign sacc = sweep && sc_q != '0 && sc_m1 < SWW'(SLOW_BUCKETS) &&
                svalid_q[sc_m1[SAW-1:0]] && in_win(sent.tag, se, 32'(SLOW_BUCKETS));

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      for (int k = 0; k < 9; k++) acc_q[k] <= '0;
    end else begin
      if (facc) begin
        acc_q[0] <= swas_pkg::add48(acc_q[0], 48'(fent.reads));
        acc_q[3] <= swas_pkg::add48(acc_q[3], 48'(fent.lookups));
      end
      if (macc) begin
        acc_q[1] <= swas_pkg::add48(acc_q[1], 48'(ment.reads));
        acc_q[4] <= swas_pkg::add48(acc_q[4], 48'(ment.lookups));
        acc_q[5] <= swas_pkg::add48(acc_q[5], 48'(ment.range_scans));
        acc_q[6] <= swas_pkg::add48(acc_q[6], 48'(ment.full_scans));
        acc_q[7] <= swas_pkg::add48(acc_q[7], ment.bytes);
        acc_q[8] <= swas_pkg::add48(acc_q[8], ment.rows);
      end
      if (sacc) begin
        acc_q[2] <= swas_pkg::add48(acc_q[2], 48'(sent.reads));
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= {4'd0, wtime_q, atime_q, acc_q[8], acc_q[7], acc_q[6], acc_q[5],
                acc_q[4], acc_q[3], acc_q[2], acc_q[1], acc_q[0]};
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_data_o    = out_q;
  assign st_o.div_last   = (dc_q == 5'(swas_pkg::DIV_STEPS - 1));
  assign st_o.sweep_last = (sc_q == SWW'(MAXN));
  assign st_o.out_free   = !out_valid_q || out_ready_i;
  assign st_o.cmd        = cmd_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before taken");
  a_rmw_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ram_wr |-> $past(cmd_i.ram_rd))
    else $error("bucket write without prior read");
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.out_load))
    else $error("result valid without load");
endmodule

### hw/rtl/sliding_window_access_stats_top.sv
// Top level of the sliding window access stats block: ports, controller, datapath.
// Depends on swas_pkg, swas_ctrl and swas_dp.
//
//  channel  dir  handshake                   payload
//  s_axis   in   s_axis_tvalid/tready        tdata 138b (144), tuser 4b
//  m_axis   out  m_axis_tvalid/tready        tdata 516b (520)
//  cfg      in   cfg_we_i                    cfg_idx_i, cfg_wdata_i
//
// Write-time update: done in the idle state. Record: 32-step serial divide, RAM read, write.
// Snapshot: serial divide, then the sweep over the bucket RAMs; then the
// result waits in the output register until taken. One item at a time. Reset clears
// the bucket valid flops at once, no clearing pass.
`timescale 1ns / 1ps
module sliding_window_access_stats_top #(
  parameter int FAST_BUCKETS = 60,
  parameter int MID_BUCKETS  = 60,
  parameter int SLOW_BUCKETS = 24
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [16:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // now_sec[31:0], bytes_scanned[63:32], rows_scanned[95:64], wr_stamp_ms[137:96]
  input  logic [143:0] s_axis_tdata,
  // command[1:0], access_type[3:2]
  input  logic [3:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // reads_fast, reads_mid, reads_slow, lookups_fast, lookups_mid, range_scans_mid,
  // full_scans_mid, bytes_mid, rows_mid (48b each), recent_access_ms, last_write_ms (42b)
  output logic [519:0] m_axis_tdata
);
  swas_pkg::ctrl_cmd_t cmd;
  swas_pkg::ctrl_st_t  st;

  swas_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_cmd_i(s_axis_tuser[1:0]), .in_ready_o(s_axis_tready),
    .st_i(st), .cmd_o(cmd)
  );

  swas_dp #(
    .FAST_BUCKETS(FAST_BUCKETS), .MID_BUCKETS(MID_BUCKETS), .SLOW_BUCKETS(SLOW_BUCKETS)
  ) u_dp (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_cmd_i(s_axis_tuser[1:0]), .in_type_i(s_axis_tuser[3:2]),
    .in_now_i(s_axis_tdata[31:0]), .in_bytes_i(s_axis_tdata[63:32]),
    .in_rows_i(s_axis_tdata[95:64]), .in_wms_i(s_axis_tdata[137:96]),
    .cmd_i(cmd), .st_o(st),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_data_o(m_axis_tdata)
  );
endmodule
